@@ sv/wmm_pkg.sv @@
// Shared types and constants for the WMM access-category transmit scheduler.
// Holds command codes, queue codes and the transaction and status structs.
// Depends on nothing; every other file imports it.
package wmm_pkg;

  localparam int NUM_Q = 4;
  localparam int QW    = 2;
  localparam int HW    = 8;
  localparam int UPW   = 8;
  localparam int CMDW  = 2;

  // Command codes.
  localparam logic [CMDW-1:0] CMD_ENQ    = 2'd0;
  localparam logic [CMDW-1:0] CMD_DEQ    = 2'd1;
  localparam logic [CMDW-1:0] CMD_RESUME = 2'd2;

  // Queue codes, highest priority first.
  localparam logic [QW-1:0] Q_VOICE       = 2'd0;
  localparam logic [QW-1:0] Q_VIDEO       = 2'd1;
  localparam logic [QW-1:0] Q_BEST_EFFORT = 2'd2;
  localparam logic [QW-1:0] Q_BACKGROUND  = 2'd3;

  // A classified transaction as it travels from the front to the back.
  typedef struct packed {
    logic [CMDW-1:0]  cmd;
    logic [QW-1:0]    queue;
    logic [HW-1:0]    handle;
    logic             enabled;
    logic [NUM_Q-1:0] dnf;
    logic [NUM_Q-1:0] act;
  } wmm_item_t;

  // Status flags of one access-category queue.
  typedef struct packed {
    logic full;
    logic almost_full;
    logic nonempty;
    logic multi;
    logic below_half;
  } wmm_qstat_t;

endpackage

@@ sv/wmm_front.sv @@
// Front end: accepts input transactions and classifies them.
// Maps the user priority to a target queue and holds one transaction.
// Depends on wmm_pkg.
module wmm_front
  import wmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMDW-1:0]  in_command,
  input  logic [HW-1:0]    in_handle,
  input  logic [UPW-1:0]   in_user_priority,
  input  logic             in_user_tx_enabled,
  input  logic [NUM_Q-1:0] in_downstream_not_full,
  input  logic [NUM_Q-1:0] in_queue_active,
  output logic             item_valid,
  output wmm_item_t        item,
  input  logic             item_full
);

  logic      valid_r, valid_nxt;
  wmm_item_t item_r;
  wmm_item_t item_nxt;
  logic      accept;

  function automatic logic [QW-1:0] map_priority(input logic [UPW-1:0] up);
    logic [QW-1:0] q;
    case (up)
      8'd7, 8'd6: q = Q_VOICE;
      8'd5, 8'd4: q = Q_VIDEO;
      8'd2, 8'd1: q = Q_BACKGROUND;
      default:    q = Q_BEST_EFFORT;
    endcase
    return q;
  endfunction

  assign in_stall = valid_r & item_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    item_nxt.cmd     = in_command;
    item_nxt.queue   = map_priority(in_user_priority);
    item_nxt.handle  = in_handle;
    item_nxt.enabled = in_user_tx_enabled;
    item_nxt.dnf     = in_downstream_not_full;
    item_nxt.act     = in_queue_active;
    valid_nxt        = accept | (valid_r & item_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ sv/wmm_cmdq.sv @@
// Two-entry transaction queue between the front and the back.
// Lets either side stall without holding up the other.
// Depends on wmm_pkg.
module wmm_cmdq
  import wmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wmm_item_t push_item,
  output logic      full,
  output logic      head_valid,
  output wmm_item_t head_item,
  input  logic      pop
);

  wmm_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_item  = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/wmm_acq.sv @@
// One access-category FIFO of packet handles with its pointers and fill count.
// The handle store is a memory with a registered read port.
// Depends on wmm_pkg.
module wmm_acq
  import wmm_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [HW-1:0] push_data,
  input  logic          pop,
  output logic [HW-1:0] rd_data,
  output wmm_qstat_t    stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_HALF = CW'(DEPTH / 2);

  logic [HW-1:0] mem [DEPTH];
  logic [HW-1:0] rd_data_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      count_nxt  = count_r + CW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      count_nxt  = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // The read data holds until the next pop, so a stalled result keeps its handle.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign rd_data          = rd_data_r;
  assign stat.full        = count_r == CNT_FULL;
  assign stat.almost_full = count_r == CNT_LAST;
  assign stat.nonempty    = count_r != '0;
  assign stat.multi       = count_r > CW'(1);
  assign stat.below_half  = count_r < CNT_HALF;

endmodule

@@ sv/wmm_back.sv @@
// Back end: executes enqueue, dequeue and resume transactions on the four queues.
// Owns the queues and the registered result stage.
// Depends on wmm_pkg and wmm_acq.
module wmm_back
  import wmm_pkg::*;
#(
  parameter int VOICE_DEPTH       = 16,
  parameter int VIDEO_DEPTH       = 16,
  parameter int BEST_EFFORT_DEPTH = 16,
  parameter int BACKGROUND_DEPTH  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  wmm_item_t     head_item,
  output logic          head_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_rejected,
  output logic [HW-1:0] out_rejected_handle,
  output logic          out_flow_go,
  output logic          out_out_valid,
  output logic [HW-1:0] out_out_handle,
  output logic [QW-1:0] out_out_queue,
  output logic          out_more,
  output logic          out_resume
);

  wmm_qstat_t       qstat   [NUM_Q];
  logic [HW-1:0]    rd_data [NUM_Q];
  logic [NUM_Q-1:0] push;
  logic [NUM_Q-1:0] pop;
  logic             fire;

  logic             pick_found;
  logic [QW-1:0]    pick_q;
  logic             more_now;
  logic             resume_now;
  logic             act_found;
  logic [NUM_Q-1:0] lower_mask;
  wmm_qstat_t       tgt;

  logic             valid_r, valid_nxt;
  logic             rejected_r, rejected_nxt;
  logic [HW-1:0]    rej_handle_r, rej_handle_nxt;
  logic             flow_go_r, flow_go_nxt;
  logic             deq_valid_r, deq_valid_nxt;
  logic [QW-1:0]    deq_queue_r, deq_queue_nxt;
  logic             more_r, more_nxt;
  logic             resume_r, resume_nxt;

  wmm_acq #(.DEPTH(VOICE_DEPTH)) u_voice (
    .clk(clk), .rst_n(rst_n), .push(push[0]), .push_data(head_item.handle),
    .pop(pop[0]), .rd_data(rd_data[0]), .stat(qstat[0])
  );
  wmm_acq #(.DEPTH(VIDEO_DEPTH)) u_video (
    .clk(clk), .rst_n(rst_n), .push(push[1]), .push_data(head_item.handle),
    .pop(pop[1]), .rd_data(rd_data[1]), .stat(qstat[1])
  );
  wmm_acq #(.DEPTH(BEST_EFFORT_DEPTH)) u_best_effort (
    .clk(clk), .rst_n(rst_n), .push(push[2]), .push_data(head_item.handle),
    .pop(pop[2]), .rd_data(rd_data[2]), .stat(qstat[2])
  );
  wmm_acq #(.DEPTH(BACKGROUND_DEPTH)) u_background (
    .clk(clk), .rst_n(rst_n), .push(push[3]), .push_data(head_item.handle),
    .pop(pop[3]), .rd_data(rd_data[3]), .stat(qstat[3])
  );

  assign fire     = head_valid & (~valid_r | ~out_stall);
  assign head_pop = fire;
  assign tgt      = qstat[head_item.queue];

  // Highest-priority queue that holds a handle and has room downstream.
  always_comb begin
    pick_found = 1'b0;
    pick_q     = Q_VOICE;
    for (int i = 0; i < NUM_Q; i++) begin
      if (!pick_found && head_item.dnf[i] && qstat[i].nonempty) begin
        pick_found = 1'b1;
        pick_q     = QW'(i);
      end
    end
  end

  // After the pop, the served queue still counts only if it held two or more.
  always_comb begin
    more_now = 1'b0;
    for (int j = 0; j < NUM_Q; j++) begin
      if (head_item.dnf[j]) begin
        if (QW'(j) == pick_q) begin
          more_now = more_now | qstat[j].multi;
        end else begin
          more_now = more_now | qstat[j].nonempty;
        end
      end
    end
  end

  always_comb begin
    act_found  = 1'b0;
    resume_now = 1'b1;
    for (int i = 0; i < NUM_Q; i++) begin
      if (!act_found && head_item.act[i]) begin
        act_found  = 1'b1;
        resume_now = qstat[i].below_half;
      end
    end
  end

  assign lower_mask = (NUM_Q'(1) << head_item.queue) - NUM_Q'(1);

  always_comb begin
    push           = '0;
    pop            = '0;
    valid_nxt      = valid_r & out_stall;
    rejected_nxt   = rejected_r;
    rej_handle_nxt = rej_handle_r;
    flow_go_nxt    = flow_go_r;
    deq_valid_nxt  = deq_valid_r;
    deq_queue_nxt  = deq_queue_r;
    more_nxt       = more_r;
    resume_nxt     = resume_r;
    if (fire) begin
      valid_nxt      = 1'b1;
      rejected_nxt   = 1'b0;
      rej_handle_nxt = '0;
      flow_go_nxt    = 1'b0;
      deq_valid_nxt  = 1'b0;
      deq_queue_nxt  = Q_VOICE;
      more_nxt       = 1'b0;
      resume_nxt     = 1'b0;
      case (head_item.cmd)
        CMD_ENQ: begin
          if (tgt.full) begin
            rejected_nxt   = 1'b1;
            rej_handle_nxt = head_item.handle;
          end else begin
            push[head_item.queue] = 1'b1;
          end
          // Go unless the queue is full after this enqueue; a full lower
          // queue may still go while some higher queue is active.
          if (!(tgt.full || tgt.almost_full)) begin
            flow_go_nxt = 1'b1;
          end else if (head_item.queue == Q_VOICE) begin
            flow_go_nxt = 1'b0;
          end else begin
            flow_go_nxt = head_item.enabled & (|(head_item.act & lower_mask));
          end
        end
        CMD_DEQ: begin
          if (pick_found) begin
            pop[pick_q]   = 1'b1;
            deq_valid_nxt = 1'b1;
            deq_queue_nxt = pick_q;
            more_nxt      = more_now;
          end
        end
        CMD_RESUME: begin
          resume_nxt = head_item.enabled & resume_now;
        end
        default: begin
          valid_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rejected_r   <= rejected_nxt;
    rej_handle_r <= rej_handle_nxt;
    flow_go_r    <= flow_go_nxt;
    deq_valid_r  <= deq_valid_nxt;
    deq_queue_r  <= deq_queue_nxt;
    more_r       <= more_nxt;
    resume_r     <= resume_nxt;
  end

  assign out_valid           = valid_r;
  assign out_rejected        = rejected_r;
  assign out_rejected_handle = rej_handle_r;
  assign out_flow_go         = flow_go_r;
  assign out_out_valid       = deq_valid_r;
  assign out_out_handle      = deq_valid_r ? rd_data[deq_queue_r] : '0;
  assign out_out_queue       = deq_queue_r;
  assign out_more            = more_r;
  assign out_resume          = resume_r;

endmodule

@@ sv/wmm_access_category_tx_scheduler_top.sv @@
// WMM access-category transmit scheduler, top level.
// A transaction passes through the front-end register, the transaction queue and the result register.
// Throughput: one transaction per cycle while the result side does not stall; the back end
// does one queue access per cycle and the two-entry transaction queue absorbs stalls.
// Reset (rst_n, synchronous, active low) empties all queues and the pipeline; the handle
// stores are not cleared and need no clearing pass, so the block is ready right after reset.
module wmm_access_category_tx_scheduler_top
  import wmm_pkg::*;
#(
  parameter int VOICE_DEPTH       = 16,
  parameter int VIDEO_DEPTH       = 16,
  parameter int BEST_EFFORT_DEPTH = 16,
  parameter int BACKGROUND_DEPTH  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel: one command transaction per handshake.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMDW-1:0]  in_command,
  input  logic [HW-1:0]    in_handle,
  input  logic [UPW-1:0]   in_user_priority,
  input  logic             in_user_tx_enabled,
  input  logic [NUM_Q-1:0] in_downstream_not_full,
  input  logic [NUM_Q-1:0] in_queue_active,
  // Result channel: one result transaction for every command.
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_rejected,
  output logic [HW-1:0]    out_rejected_handle,
  output logic             out_flow_go,
  output logic             out_out_valid,
  output logic [HW-1:0]    out_out_handle,
  output logic [QW-1:0]    out_out_queue,
  output logic             out_more,
  output logic             out_resume
);

  // The front end registers each transaction and resolves the user priority
  // to its access category. The transaction queue then decouples it from the
  // back end, which owns the four handle FIFOs and the result register.
  logic      front_valid;
  wmm_item_t front_item;
  logic      cmdq_full;
  logic      head_valid;
  wmm_item_t head_item;
  logic      head_pop;

  wmm_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_handle              (in_handle),
    .in_user_priority       (in_user_priority),
    .in_user_tx_enabled     (in_user_tx_enabled),
    .in_downstream_not_full (in_downstream_not_full),
    .in_queue_active        (in_queue_active),
    .item_valid             (front_valid),
    .item                   (front_item),
    .item_full              (cmdq_full)
  );

  wmm_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_valid),
    .push_item  (front_item),
    .full       (cmdq_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (head_pop)
  );

  // Dequeue serves voice, video, best effort, background in strict order,
  // skipping any queue whose downstream slot is full.
  wmm_back #(
    .VOICE_DEPTH       (VOICE_DEPTH),
    .VIDEO_DEPTH       (VIDEO_DEPTH),
    .BEST_EFFORT_DEPTH (BEST_EFFORT_DEPTH),
    .BACKGROUND_DEPTH  (BACKGROUND_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .head_pop            (head_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_rejected        (out_rejected),
    .out_rejected_handle (out_rejected_handle),
    .out_flow_go         (out_flow_go),
    .out_out_valid       (out_out_valid),
    .out_out_handle      (out_out_handle),
    .out_out_queue       (out_out_queue),
    .out_more            (out_more),
    .out_resume          (out_resume)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the WMM access-category transmit scheduler top level.
// Depends on wmm_pkg and wmm_access_category_tx_scheduler_top; needs no other files.
module testbench;
  import wmm_pkg::*;

  // The block is built with its default queue depths, and the predictor uses the same.
  localparam int VOICE_DEPTH       = 16;
  localparam int VIDEO_DEPTH       = 16;
  localparam int BEST_EFFORT_DEPTH = 16;
  localparam int BACKGROUND_DEPTH  = 16;
  localparam int STORE_MAX         = 256;

  // Command code 3 has no name in the package. The block must ignore it and return all zeros.
  localparam logic [CMDW-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD    = 300;   // Cycles of the one long result-side hold-off.
  localparam int IDLE_LIMIT   = 4000;  // Cycles without any handshake before giving up.
  localparam int HOLD_AT      = 150;   // Random item at which the long hold-off starts.
  localparam int PAUSE_AT     = 350;   // Random item at which the sender waits for a full drain.

  // One command transaction, as the sender offers it.
  typedef struct packed {
    logic [CMDW-1:0]  cmd;
    logic [HW-1:0]    handle;
    logic [UPW-1:0]   prio;
    logic             tx_en;
    logic [NUM_Q-1:0] room;
    logic [NUM_Q-1:0] active;
  } sched_cmd_t;

  // One result transaction, as the block returns it.
  typedef struct packed {
    logic          rejected;
    logic [HW-1:0] rej_handle;
    logic          flow_go;
    logic          served;
    logic [HW-1:0] served_handle;
    logic [QW-1:0] served_queue;
    logic          more;
    logic          resume;
  } sched_outcome_t;

  // Random traffic comes in segments. Each segment has one character: it piles into one
  // access category until the queue is full, or it mostly drains, or it mixes everything.
  typedef enum int {FILL_ONE, DRAIN, MIXED} traffic_mode_t;

  // Tracks the four access-category queues the way the block should. It works out the
  // outcome of each accepted command and compares the returned results in order.
  class ac_queue_tracker;
    logic [HW-1:0]  slots [NUM_Q][STORE_MAX];
    int             depth [NUM_Q];
    int             rd_ptr [NUM_Q];
    int             wr_ptr [NUM_Q];
    int             fill [NUM_Q];
    sched_outcome_t awaited [$];
    int mismatches, n_checked;
    int n_enq, n_rej, n_stop, n_served, n_idle_deq, n_resume, n_unused;

    function new();
      depth[0] = VOICE_DEPTH;
      depth[1] = VIDEO_DEPTH;
      depth[2] = BEST_EFFORT_DEPTH;
      depth[3] = BACKGROUND_DEPTH;
      for (int q = 0; q < NUM_Q; q++) begin
        rd_ptr[q] = 0;
        wr_ptr[q] = 0;
        fill[q]   = 0;
      end
    endfunction

    // 802.1D user priority to access category.
    function int ac_of_priority(logic [UPW-1:0] up);
      if (up == 8'd7 || up == 8'd6) return int'(Q_VOICE);
      if (up == 8'd5 || up == 8'd4) return int'(Q_VIDEO);
      if (up == 8'd2 || up == 8'd1) return int'(Q_BACKGROUND);
      return int'(Q_BEST_EFFORT);
    endfunction

    // Highest-priority queue that holds a handle and has downstream room, else NUM_Q.
    function int ready_queue(logic [NUM_Q-1:0] room);
      int q, pick;
      pick = NUM_Q;
      for (q = NUM_Q - 1; q >= 0; q--)
        if (room[q] && fill[q] != 0) pick = q;
      return pick;
    endfunction

    // A client may go on sending unless its queue is now full. A full lower-priority
    // queue is tolerated while user data is enabled and some higher category is active.
    function logic go_decision(int q, logic tx_en, logic [NUM_Q-1:0] active);
      logic [NUM_Q-1:0] higher;
      if (fill[q] < depth[q]) return 1'b1;
      if (q == int'(Q_VOICE)) return 1'b0;
      if (!tx_en) return 1'b0;
      higher = (4'd1 << q) - 4'd1;
      return (active & higher) != 0;
    endfunction

    function void note_command(sched_cmd_t c);
      sched_outcome_t o;
      int q, k;
      o = '0;
      case (c.cmd)
        CMD_ENQ: begin
          q = ac_of_priority(c.prio);
          n_enq++;
          if (fill[q] >= depth[q]) begin
            o.rejected   = 1'b1;
            o.rej_handle = c.handle;
            n_rej++;
          end else begin
            slots[q][wr_ptr[q]] = c.handle;
            wr_ptr[q] = (wr_ptr[q] + 1) % depth[q];
            fill[q]++;
          end
          o.flow_go = go_decision(q, c.tx_en, c.active);
          if (!o.flow_go) n_stop++;
        end
        CMD_DEQ: begin
          q = ready_queue(c.room);
          if (q < NUM_Q) begin
            o.served        = 1'b1;
            o.served_handle = slots[q][rd_ptr[q]];
            o.served_queue  = q[QW-1:0];
            rd_ptr[q] = (rd_ptr[q] + 1) % depth[q];
            fill[q]--;
            o.more = ready_queue(c.room) < NUM_Q;
            n_served++;
          end else begin
            n_idle_deq++;
          end
        end
        CMD_RESUME: begin
          n_resume++;
          if (c.tx_en) begin
            // Walk from the lowest priority up, so the highest active category decides.
            o.resume = 1'b1;
            for (k = NUM_Q - 1; k >= 0; k--)
              if (c.active[k]) o.resume = fill[k] < depth[k] / 2;
          end
        end
        default: n_unused++;
      endcase
      awaited.push_back(o);
    endfunction

    function string show(sched_outcome_t o);
      return $sformatf("rej=%0d rej_h=%02h go=%0d served=%0d h=%02h q=%0d more=%0d resume=%0d",
                       o.rejected, o.rej_handle, o.flow_go, o.served, o.served_handle,
                       o.served_queue, o.more, o.resume);
    endfunction

    function void check_outcome(sched_outcome_t got);
      sched_outcome_t want;
      n_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d arrived with nothing outstanding: %s",
                   n_checked, show(got));
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d\n  expected %s\n  actual   %s",
                     n_checked, show(want), show(got));
        end
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [CMDW-1:0]  in_command = '0;
  logic [HW-1:0]    in_handle = '0;
  logic [UPW-1:0]   in_user_priority = '0;
  logic             in_user_tx_enabled = 1'b0;
  logic [NUM_Q-1:0] in_downstream_not_full = '0;
  logic [NUM_Q-1:0] in_queue_active = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             out_rejected;
  logic [HW-1:0]    out_rejected_handle;
  logic             out_flow_go;
  logic             out_out_valid;
  logic [HW-1:0]    out_out_handle;
  logic [QW-1:0]    out_out_queue;
  logic             out_more;
  logic             out_resume;

  ac_queue_tracker sb;

  // The sender raises hold_req once; the receiver notes in hold_taken that it has started
  // the long hold-off, so each flag has a single driving process.
  logic           hold_req = 1'b0;
  logic           hold_taken = 1'b0;
  int             hold_left = 0;
  int             stall_style = 0;
  int             rx_cycle = 0;
  int             idle_cycles = 0;
  sched_outcome_t result_seen;

  wmm_access_category_tx_scheduler_top #(
    .VOICE_DEPTH      (VOICE_DEPTH),
    .VIDEO_DEPTH      (VIDEO_DEPTH),
    .BEST_EFFORT_DEPTH(BEST_EFFORT_DEPTH),
    .BACKGROUND_DEPTH (BACKGROUND_DEPTH)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_handle             (in_handle),
    .in_user_priority      (in_user_priority),
    .in_user_tx_enabled    (in_user_tx_enabled),
    .in_downstream_not_full(in_downstream_not_full),
    .in_queue_active       (in_queue_active),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rejected          (out_rejected),
    .out_rejected_handle   (out_rejected_handle),
    .out_flow_go           (out_flow_go),
    .out_out_valid         (out_out_valid),
    .out_out_handle        (out_out_handle),
    .out_out_queue         (out_out_queue),
    .out_more              (out_more),
    .out_resume            (out_resume)
  );

  always #1 clk = ~clk;

  // Offers one command and holds it until the block takes it. The stall is sampled at the
  // clock edge, so its value is the one the block registered the acceptance against. The
  // command is recorded with the tracker in the same step, before its result can
  // become valid.
  task automatic send_cmd(input sched_cmd_t c);
    in_valid               <= 1'b1;
    in_command             <= c.cmd;
    in_handle              <= c.handle;
    in_user_priority       <= c.prio;
    in_user_tx_enabled     <= c.tx_en;
    in_downstream_not_full <= c.room;
    in_queue_active        <= c.active;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(c);
  endtask

  task automatic send_fields(input logic [CMDW-1:0] cmd, input logic [HW-1:0] handle,
                             input logic [UPW-1:0] prio, input logic tx_en,
                             input logic [NUM_Q-1:0] room, input logic [NUM_Q-1:0] active);
    sched_cmd_t c;
    c = '{cmd: cmd, handle: handle, prio: prio, tx_en: tx_en, room: room, active: active};
    send_cmd(c);
  endtask

  // Takes the bus to idle and holds off until every outstanding result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Directed opening: empty-queue behavior, every priority class including the
  // best-effort fallbacks for 0, 3 and values above 7, handle extremes, user tx disabled,
  // a resume with nothing active, the unused command code, a dequeue with no downstream
  // room, dequeues steered by the room mask, and a drain down past empty.
  task automatic run_directed();
    send_fields(CMD_RESUME, 8'h00, 8'h00, 1'b1, 4'hF, 4'h0);
    send_fields(CMD_DEQ,    8'h00, 8'h00, 1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'h00, 8'd7,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'hFF, 8'd6,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'hA5, 8'd5,   1'b1, 4'hF, 4'h0);
    send_fields(CMD_ENQ,    8'h5A, 8'd4,   1'b0, 4'h0, 4'hF);
    send_fields(CMD_ENQ,    8'h01, 8'd3,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'h80, 8'd0,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'h7F, 8'd8,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'hFE, 8'd255, 1'b0, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'h11, 8'd2,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_ENQ,    8'h22, 8'd1,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_RESUME, 8'h00, 8'h00, 1'b0, 4'hF, 4'hF);
    send_fields(CMD_RESUME, 8'h00, 8'h00, 1'b1, 4'hF, 4'b0100);
    send_fields(CMD_UNUSED, 8'hC3, 8'd7,   1'b1, 4'hF, 4'hF);
    send_fields(CMD_DEQ,    8'h00, 8'h00, 1'b1, 4'h0, 4'hF);
    send_fields(CMD_DEQ,    8'h00, 8'h00, 1'b1, 4'b1000, 4'hF);
    send_fields(CMD_DEQ,    8'h00, 8'h00, 1'b1, 4'b0110, 4'hF);
    repeat (9) send_fields(CMD_DEQ, 8'h00, 8'h00, 1'b1, 4'hF, 4'hF);
  endtask

  function automatic logic [UPW-1:0] random_priority();
    if ($urandom_range(0, 1) == 0) return UPW'($urandom_range(0, 255));
    return UPW'($urandom_range(0, 7));
  endfunction

  function automatic sched_cmd_t random_cmd(traffic_mode_t mode, int target);
    sched_cmd_t c;
    int pick;
    c.handle = HW'($urandom_range(0, 255));
    c.prio   = random_priority();
    c.tx_en  = ($urandom_range(0, 9) != 0);
    c.active = NUM_Q'($urandom_range(0, 15));
    c.room   = ($urandom_range(0, 2) == 0) ? NUM_Q'($urandom_range(0, 15)) : 4'hF;
    pick = $urandom_range(0, 99);
    case (mode)
      FILL_ONE: begin
        c.cmd = (pick < 80) ? CMD_ENQ : (pick < 90) ? CMD_DEQ : CMD_RESUME;
        // Most enqueues in a fill segment aim at one category so that its queue overflows.
        if ($urandom_range(0, 3) != 0) begin
          case (target)
            0: c.prio = UPW'(6 + $urandom_range(0, 1));
            1: c.prio = UPW'(4 + $urandom_range(0, 1));
            3: c.prio = UPW'(1 + $urandom_range(0, 1));
            default: c.prio = ($urandom_range(0, 1) == 0) ? UPW'($urandom_range(8, 255))
                                                          : UPW'(3 * $urandom_range(0, 1));
          endcase
        end
      end
      DRAIN: c.cmd = (pick < 75) ? CMD_DEQ : (pick < 88) ? CMD_ENQ : CMD_RESUME;
      default: c.cmd = (pick < 40) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                       (pick < 98) ? CMD_RESUME : CMD_UNUSED;
    endcase
    return c;
  endfunction

  // Main stimulus. After reset and the directed opening, random traffic comes in bursts
  // of random length. About a third of the bursts run straight on with no gap, so there
  // are stretches where the bus never idles. Partway through, the receiver is asked for
  // a long hold-off while the sender keeps offering items, which fills the pipeline and
  // forces the input stall. Later the sender stops until every result has returned.
  initial begin
    traffic_mode_t mode;
    int target, seg_left, burst, issued, iter;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    issued   = 0;
    iter     = 0;
    seg_left = 0;
    mode     = MIXED;
    target   = 0;
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && issued < RANDOM_ITEMS) begin
        if (seg_left == 0) begin
          mode     = traffic_mode_t'($urandom_range(0, 2));
          target   = $urandom_range(0, NUM_Q - 1);
          seg_left = $urandom_range(20, 60);
        end
        if (iter == HOLD_AT) hold_req <= 1'b1;
        if (iter == PAUSE_AT) wait_for_drain();
        send_cmd(random_cmd(mode, target));
        // Ignored commands do not count toward the random item total.
        if (in_command != CMD_UNUSED) issued++;
        iter++;
        seg_left--;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end

    // Let every result come back, then give the pipeline time to show any
    // stray result that should not exist.
    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d enqueues (%0d rejected, %0d flow stops), %0d dequeues served,",
             sb.n_enq, sb.n_rej, sb.n_stop, sb.n_served);
    $display("%0d dequeues with nothing to send, %0d resume queries, %0d unused commands.",
             sb.n_idle_deq, sb.n_resume, sb.n_unused);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.awaited.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver. Checks each accepted result, then picks the stall for the next cycle. The
  // stall style is redrawn at random among never, light random, heavy random and a
  // fixed period, so stalls land on every phase of the pipeline. A long hold-off,
  // requested by the sender, overrides the style and is counted down here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        result_seen.rejected      = out_rejected;
        result_seen.rej_handle    = out_rejected_handle;
        result_seen.flow_go       = out_flow_go;
        result_seen.served        = out_out_valid;
        result_seen.served_handle = out_out_handle;
        result_seen.served_queue  = out_out_queue;
        result_seen.more          = out_more;
        result_seen.resume        = out_resume;
        sb.check_outcome(result_seen);
      end
      rx_cycle++;
      if (hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (rx_cycle % 48 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (rx_cycle % 5 < 2);
        endcase
      end
    end
  end

  // Watchdog. Any handshake on either side counts as progress. The longest legal quiet
  // stretch is the receiver's long hold-off, far below the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

endmodule

@@ sim.f @@
sv/wmm_pkg.sv
sv/wmm_front.sv
sv/wmm_cmdq.sv
sv/wmm_acq.sv
sv/wmm_back.sv
sv/wmm_access_category_tx_scheduler_top.sv
tb/testbench.sv
